// ===== hdl/ffdc_pkg.sv =====
// Shared constants, types and codes for the face flux divergence correction core.
// No dependencies; imported by ffdc_corr_unit and the top level.
`default_nettype none

package ffdc_pkg;

    // Store geometry
    localparam int CELL_COUNT = 4096;
    localparam int SUM_WIDTH  = 40;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    // Fixed field widths
    localparam int CELL_IDX_W = 12;
    localparam int VAL_W      = 32;

    // Product accumulator: |sum| * |val| * |scal| plus the rounding half
    localparam int ACC_W = SUM_WIDTH + 64;

    // Request function codes
    localparam logic [1:0] FUNC_INTERNAL  = 2'd0;
    localparam logic [1:0] FUNC_BOUNDARY  = 2'd1;
    localparam logic [1:0] FUNC_PROCESSOR = 2'd2;
    localparam logic [1:0] FUNC_READOUT   = 2'd3;

    // Operands handed to the correction unit
    typedef struct packed {
        logic [SUM_WIDTH-1:0] a_mag;     // magnitude of the cell sum
        logic                 neg;       // sign of the full product
        logic [VAL_W-1:0]     val_mag;   // magnitude of the cell value
        logic [VAL_W-1:0]     scal_mag;  // magnitude of the cell scaling
        logic [VAL_W-1:0]     prior;     // prior result, two's complement
    } t_corr_req;

    // Response from the correction unit
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } t_corr_rsp;

endpackage

`default_nettype wire

// ===== hdl/face_flux_divergence_correction_core.sv =====
// Top level: per-cell net outflow store with read-modify-write face scatter
// and cell readout. Uses ffdc_pkg and ffdc_corr_unit.
//
//  channel  | handshake            | fields
//  ---------+----------------------+--------------------------------------------
//  request  | start in, busy out   | i_func, i_owner_cell, i_neighbour_cell,
//           |                      | i_face_flux, i_local_is_owner, i_cell_index,
//           |                      | i_cell_value, i_cell_scaling, i_prior_result
//  result   | o_strobe out         | o_result_cell, o_corrected_result
//
// A request is taken when start is high and busy is low. Boundary and
// processor-boundary faces hold busy for one cell update, internal faces for
// two: each cell update is a read and a write-back of the store. A readout
// holds busy while the shared 32x32 multiplier steps through the product; its
// result strobes for one cycle as busy drops. After reset the store is cleared
// one entry a cycle, with busy high until all CELL_COUNT (4096) entries are
// cleared. The result side cannot stall.
`default_nettype none

module face_flux_divergence_correction_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_func,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0] i_owner_cell,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0] i_neighbour_cell,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0] i_face_flux,
    input  wire logic                           i_local_is_owner,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0] i_cell_index,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0] i_cell_value,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0] i_cell_scaling,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0] i_prior_result,
    output logic                                o_strobe,
    output logic [ffdc_pkg::CELL_IDX_W-1:0]     o_result_cell,
    output logic signed [ffdc_pkg::VAL_W-1:0]   o_corrected_result
);
    import ffdc_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_CORR  = 3'd4;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

    // Cell store
    logic signed [SUM_WIDTH-1:0] mem [CELL_COUNT];

    logic [2:0]                  r_state, n_state;
    logic [ADDR_W-1:0]           r_clr;
    logic [ADDR_W-1:0]           r_addr;
    logic                        r_ok;
    logic [ADDR_W-1:0]           r_nei_addr;
    logic                        r_nei_ok;
    logic                        r_second;
    logic                        r_is_read;
    logic signed [32:0]          r_delta;
    logic signed [SUM_WIDTH-1:0] r_rdata;
    logic [CELL_IDX_W-1:0]       r_cell;
    t_corr_req                   r_req;
    logic                        r_strobe;
    logic [CELL_IDX_W-1:0]       r_out_cell;
    logic [VAL_W-1:0]            r_out_result;

    logic                        accept;
    logic signed [32:0]          flux_ext;
    logic signed [SUM_WIDTH:0]   sum_ext;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [SUM_WIDTH-1:0] read_sum;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic signed [SUM_WIDTH-1:0] mem_wdata;
    logic                        corr_start;
    t_corr_req                   corr_req;
    t_corr_rsp                   corr_rsp;

    function automatic logic cell_ok(input logic [CELL_IDX_W-1:0] idx);
        return 32'(idx) < 32'(CELL_COUNT);
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign flux_ext = 33'(i_face_flux);

    // Saturating add of the face contribution to the stored sum
    assign sum_ext = (SUM_WIDTH+1)'(r_rdata) + (SUM_WIDTH+1)'(r_delta);
    always_comb begin
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            sum_sat = sum_ext[SUM_WIDTH]
                    ? $signed({1'b1, {(SUM_WIDTH-1){1'b0}}})
                    : $signed({1'b0, {(SUM_WIDTH-1){1'b1}}});
        end else begin
            sum_sat = sum_ext[SUM_WIDTH-1:0];
        end
    end

    // Readout: an out-of-range cell reads as zero
    assign read_sum = r_ok ? r_rdata : '0;

    // Store write port: clearing sweep, face update or readout clear
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
        end else if (r_state == S_MOD && r_ok) begin
            mem_we    = 1'b1;
            mem_wdata = r_is_read ? '0 : sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[r_addr];
    end

    // Operands for the correction unit
    always_comb begin
        corr_req       = r_req;
        corr_req.a_mag = read_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-read_sum)
                                               : SUM_WIDTH'(read_sum);
        corr_req.neg   = r_req.neg ^ read_sum[SUM_WIDTH-1];
    end
    assign corr_start = (r_state == S_MOD) && r_is_read;

    ffdc_corr_unit u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (corr_start),
        .i_req   (corr_req),
        .o_rsp   (corr_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_MOD;
            S_MOD: begin
                if (r_is_read)     n_state = S_CORR;
                else if (r_second) n_state = S_READ;
                else               n_state = S_IDLE;
            end
            S_CORR:  if (corr_rsp.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_CORR) && corr_rsp.done;
            if (r_state == S_CLEAR) r_clr <= r_clr + ADDR_W'(1);
        end
    end

    // Latch the request and step through its cell updates
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read  <= (i_func == FUNC_READOUT);
            r_second   <= (i_func == FUNC_INTERNAL);
            r_nei_addr <= ADDR_W'(i_neighbour_cell);
            r_nei_ok   <= cell_ok(i_neighbour_cell);
            r_cell     <= i_cell_index;
            case (i_func)
                FUNC_INTERNAL, FUNC_BOUNDARY: begin
                    r_addr  <= ADDR_W'(i_owner_cell);
                    r_ok    <= cell_ok(i_owner_cell);
                    r_delta <= flux_ext;
                end
                FUNC_PROCESSOR: begin
                    r_addr  <= ADDR_W'(i_owner_cell);
                    r_ok    <= cell_ok(i_owner_cell);
                    r_delta <= i_local_is_owner ? flux_ext : -flux_ext;
                end
                default: begin
                    r_addr  <= ADDR_W'(i_cell_index);
                    r_ok    <= cell_ok(i_cell_index);
                    r_delta <= flux_ext;
                end
            endcase
            r_req.a_mag    <= '0;
            r_req.neg      <= i_cell_value[VAL_W-1] ^ i_cell_scaling[VAL_W-1];
            r_req.val_mag  <= i_cell_value[VAL_W-1] ? VAL_W'(-i_cell_value)
                                                    : VAL_W'(i_cell_value);
            r_req.scal_mag <= i_cell_scaling[VAL_W-1] ? VAL_W'(-i_cell_scaling)
                                                      : VAL_W'(i_cell_scaling);
            r_req.prior    <= i_prior_result;
        end else if (r_state == S_MOD && !r_is_read && r_second) begin
            // advance to the neighbour with the negated flux
            r_addr   <= r_nei_addr;
            r_ok     <= r_nei_ok;
            r_delta  <= -r_delta;
            r_second <= 1'b0;
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_CORR && corr_rsp.done) begin
            r_out_cell   <= r_cell;
            r_out_result <= corr_rsp.result;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_result_cell      = r_out_cell;
    assign o_corrected_result = $signed(r_out_result);

endmodule

`default_nettype wire

// ===== hdl/ffdc_corr_unit.sv =====
// Readout correction: prior - round(sum * value * scaling), saturated to 32 bits.
// One shared 32x32 multiplier stepped over partial products; uses ffdc_pkg.
`default_nettype none

module ffdc_corr_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire ffdc_pkg::t_corr_req i_req,
    output ffdc_pkg::t_corr_rsp      o_rsp
);
    import ffdc_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MULB = 2'd1;
    localparam logic [1:0] C_PART = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_step;
    t_corr_req        r_req;
    logic [63:0]      r_b;
    logic [63:0]      r_pp;
    logic [1:0]       r_pp_sh;
    logic [ACC_W-1:0] r_acc;
    logic             r_done;
    logic [VAL_W-1:0] r_result;

    logic [63:0]      a_ext;
    logic [31:0]      op_x, op_y;
    logic [1:0]       sh_sel;
    logic [63:0]      mul_out;
    logic [ACC_W-1:0] pp_shifted;
    logic             ovf;
    logic [31:0]      p_mag;
    logic signed [33:0] prior_ext, p_ext, diff;
    logic [VAL_W-1:0] sat_result;

    assign a_ext = 64'(r_req.a_mag);

    // Select multiplier operands: value x scaling first, then the four partials
    always_comb begin
        op_x   = r_req.val_mag;
        op_y   = r_req.scal_mag;
        sh_sel = 2'd0;
        if (r_state == C_PART) begin
            case (r_step[1:0])
                2'd0: begin
                    op_x = a_ext[31:0];  op_y = r_b[31:0];  sh_sel = 2'd0;
                end
                2'd1: begin
                    op_x = a_ext[31:0];  op_y = r_b[63:32]; sh_sel = 2'd1;
                end
                2'd2: begin
                    op_x = a_ext[63:32]; op_y = r_b[31:0];  sh_sel = 2'd1;
                end
                default: begin
                    op_x = a_ext[63:32]; op_y = r_b[63:32]; sh_sel = 2'd2;
                end
            endcase
        end
    end

    assign mul_out = op_x * op_y;

    // Align the registered partial product to its word position
    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shifted = ACC_W'(r_pp);
            2'd1:    pp_shifted = ACC_W'(r_pp) << 32;
            default: pp_shifted = ACC_W'(r_pp) << 64;
        endcase
    end

    // Saturate: product beyond Q16.16 range, then the final subtract
    assign ovf       = |r_acc[ACC_W-1:64];
    assign p_mag     = r_acc[63:32];
    assign prior_ext = 34'($signed(r_req.prior));
    assign p_ext     = $signed({2'b00, p_mag});
    assign diff      = r_req.neg ? (prior_ext + p_ext) : (prior_ext - p_ext);

    always_comb begin
        if (ovf) begin
            sat_result = r_req.neg ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111) begin
            sat_result = diff[31:0];
        end else begin
            sat_result = diff[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // Sequence: latch, value x scaling, four partial products, finish
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: if (i_start) n_state = C_MULB;
            C_MULB: n_state = C_PART;
            C_PART: if (r_step == LAST_STEP) n_state = C_FIN;
            C_FIN:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_FIN);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_start) r_req <= i_req;
            end
            C_MULB: begin
                r_b    <= mul_out;
                r_acc  <= ACC_W'(1) << 31;
                r_step <= 3'd0;
            end
            C_PART: begin
                if (r_step != 3'd0) r_acc <= r_acc + pp_shifted;
                if (r_step != LAST_STEP) begin
                    r_pp    <= mul_out;
                    r_pp_sh <= sh_sel;
                end
                r_step <= r_step + 3'd1;
            end
            C_FIN: begin
                r_result <= sat_result;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

`default_nettype wire

// ===== test/ffdc_outflow_checker.sv =====
// Checker for the face flux divergence correction core: mirrors the per-cell
// net outflow store, predicts each readout and compares it with the result port.
// Depends on ffdc_pkg for widths, store geometry and request codes.
`default_nettype none

module ffdc_outflow_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic                                 i_busy,
    input  wire logic [1:0]                           i_func,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0]      i_owner_cell,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0]      i_neighbour_cell,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0]    i_face_flux,
    input  wire logic                                 i_local_is_owner,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0]      i_cell_index,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0]    i_cell_value,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0]    i_cell_scaling,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0]    i_prior_result,
    input  wire logic                                 i_strobe,
    input  wire logic [ffdc_pkg::CELL_IDX_W-1:0]      i_result_cell,
    input  wire logic signed [ffdc_pkg::VAL_W-1:0]    i_corrected_result,
    output int                                        o_fail_count,
    output int                                        o_pending
);
    import ffdc_pkg::*;

    typedef struct {
        logic [CELL_IDX_W-1:0]   cell_id;
        logic signed [VAL_W-1:0] value;
    } t_readout;

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic signed [SUM_WIDTH-1:0] outflow_sum_model [CELL_COUNT];
    t_readout                    readout_queue [$];
    int                          fail_total = 0;
    int                          mismatches_shown = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Add a flux contribution into one cell, saturating at the sum width
    function automatic void scatter_flux(logic [CELL_IDX_W-1:0] cell_idx, longint delta);
        longint acc;
        if (cell_idx < CELL_COUNT) begin
            acc = longint'(outflow_sum_model[cell_idx]) + delta;
            if (acc > SUM_MAX)
                acc = SUM_MAX;
            else if (acc < SUM_MIN)
                acc = SUM_MIN;
            outflow_sum_model[cell_idx] = acc[SUM_WIDTH-1:0];
        end
    endfunction

    // prior - round(sum * value * scaling) in Q16.16, saturated to 32 bits
    function automatic logic signed [VAL_W-1:0] corrected_readout(
        logic signed [SUM_WIDTH-1:0] sum,
        logic signed [VAL_W-1:0]     val,
        logic signed [VAL_W-1:0]     scal,
        logic signed [VAL_W-1:0]     prior
    );
        logic                 neg;
        logic [SUM_WIDTH-1:0] sum_mag;
        logic [VAL_W-1:0]     val_mag;
        logic [VAL_W-1:0]     scal_mag;
        logic [127:0]         prod;
        longint               p;
        longint               r;
        neg      = sum[SUM_WIDTH-1] ^ val[VAL_W-1] ^ scal[VAL_W-1];
        sum_mag  = sum[SUM_WIDTH-1] ? -sum : sum;
        val_mag  = val[VAL_W-1] ? -val : val;
        scal_mag = scal[VAL_W-1] ? -scal : scal;
        // exact Q56.48 product, then add half an output LSB (ties away from zero)
        prod = 128'(sum_mag) * 128'(val_mag) * 128'(scal_mag);
        prod = prod + 128'h8000_0000;
        if (prod[127:64] != '0)
            return neg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        p = longint'(prod[63:32]);
        if (neg)
            p = -p;
        r = longint'(prior) - p;
        if (r > longint'(32'sh7FFF_FFFF))
            r = longint'(32'sh7FFF_FFFF);
        else if (r < longint'(32'sh8000_0000))
            r = longint'(32'sh8000_0000);
        return r[VAL_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_readout                    exp_r;
        logic signed [SUM_WIDTH-1:0] cell_sum;
        if (!i_rst_n) begin
            foreach (outflow_sum_model[k])
                outflow_sum_model[k] = '0;
            readout_queue.delete();
        end else begin
            // Compare a result against the oldest pending readout
            if (i_strobe) begin
                if (readout_queue.size() == 0) begin
                    fail_total++;
                    if (mismatches_shown < 10) begin
                        mismatches_shown++;
                        $display("unexpected result: cell %0d value %h",
                                 i_result_cell, i_corrected_result);
                    end
                end else begin
                    exp_r = readout_queue.pop_front();
                    if (i_result_cell !== exp_r.cell_id ||
                        i_corrected_result !== exp_r.value) begin
                        fail_total++;
                        if (mismatches_shown < 10) begin
                            mismatches_shown++;
                            $display("readout mismatch: cell exp %0d got %0d, value exp %h got %h",
                                     exp_r.cell_id, i_result_cell, exp_r.value,
                                     i_corrected_result);
                        end
                    end
                end
            end

            // Apply an accepted request to the store model
            if (i_start && !i_busy) begin
                case (i_func)
                    FUNC_INTERNAL: begin
                        scatter_flux(i_owner_cell, longint'(i_face_flux));
                        scatter_flux(i_neighbour_cell, -longint'(i_face_flux));
                    end
                    FUNC_BOUNDARY: begin
                        scatter_flux(i_owner_cell, longint'(i_face_flux));
                    end
                    FUNC_PROCESSOR: begin
                        scatter_flux(i_owner_cell, i_local_is_owner ? longint'(i_face_flux)
                                                                    : -longint'(i_face_flux));
                    end
                    FUNC_READOUT: begin
                        cell_sum = '0;
                        if (i_cell_index < CELL_COUNT) begin
                            cell_sum = outflow_sum_model[i_cell_index];
                            outflow_sum_model[i_cell_index] = '0;
                        end
                        exp_r.cell_id = i_cell_index;
                        exp_r.value   = corrected_readout(cell_sum, i_cell_value,
                                                          i_cell_scaling, i_prior_result);
                        readout_queue.push_back(exp_r);
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= readout_queue.size();
    end

endmodule

`default_nettype wire

// ===== test/face_flux_divergence_correction_core_tb.sv =====
// Testbench top for the face flux divergence correction core: drives directed,
// saturating and random face and readout requests and gives the verdict.
// Depends on ffdc_pkg, ffdc_outflow_checker and the core itself.
`default_nettype none

module face_flux_divergence_correction_core_tb;
    import ffdc_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SAT_FACES    = 264;
    localparam int RANDOM_ITEMS = 660;
    localparam int CALM_TAIL    = 150;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    start            = 1'b0;
    logic [1:0]              i_func           = '0;
    logic [CELL_IDX_W-1:0]   i_owner_cell     = '0;
    logic [CELL_IDX_W-1:0]   i_neighbour_cell = '0;
    logic signed [VAL_W-1:0] i_face_flux      = '0;
    logic                    i_local_is_owner = 1'b0;
    logic [CELL_IDX_W-1:0]   i_cell_index     = '0;
    logic signed [VAL_W-1:0] i_cell_value     = '0;
    logic signed [VAL_W-1:0] i_cell_scaling   = '0;
    logic signed [VAL_W-1:0] i_prior_result   = '0;
    logic                    busy;
    logic                    o_strobe;
    logic [CELL_IDX_W-1:0]   o_result_cell;
    logic signed [VAL_W-1:0] o_corrected_result;

    int fail_count;
    int pending_readouts;
    int idle_cycles = 0;
    int gap_pct     = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    face_flux_divergence_correction_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_owner_cell       (i_owner_cell),
        .i_neighbour_cell   (i_neighbour_cell),
        .i_face_flux        (i_face_flux),
        .i_local_is_owner   (i_local_is_owner),
        .i_cell_index       (i_cell_index),
        .i_cell_value       (i_cell_value),
        .i_cell_scaling     (i_cell_scaling),
        .i_prior_result     (i_prior_result),
        .o_strobe           (o_strobe),
        .o_result_cell      (o_result_cell),
        .o_corrected_result (o_corrected_result)
    );

    ffdc_outflow_checker outflow_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_func             (i_func),
        .i_owner_cell       (i_owner_cell),
        .i_neighbour_cell   (i_neighbour_cell),
        .i_face_flux        (i_face_flux),
        .i_local_is_owner   (i_local_is_owner),
        .i_cell_index       (i_cell_index),
        .i_cell_value       (i_cell_value),
        .i_cell_scaling     (i_cell_scaling),
        .i_prior_result     (i_prior_result),
        .i_strobe           (o_strobe),
        .i_result_cell      (o_result_cell),
        .i_corrected_result (o_corrected_result),
        .o_fail_count       (fail_count),
        .o_pending          (pending_readouts)
    );

    // Hold a request until the core takes it, then maybe idle for a short burst
    task automatic send_request(
        input logic [1:0]              func,
        input logic [CELL_IDX_W-1:0]   own,
        input logic [CELL_IDX_W-1:0]   nei,
        input logic signed [VAL_W-1:0] flux,
        input logic                    lio,
        input logic [CELL_IDX_W-1:0]   cell_idx,
        input logic signed [VAL_W-1:0] val,
        input logic signed [VAL_W-1:0] scal,
        input logic signed [VAL_W-1:0] prior
    );
        i_func           <= func;
        i_owner_cell     <= own;
        i_neighbour_cell <= nei;
        i_face_flux      <= flux;
        i_local_is_owner <= lio;
        i_cell_index     <= cell_idx;
        i_cell_value     <= val;
        i_cell_scaling   <= scal;
        i_prior_result   <= prior;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Q16.16 operand: extremes, zero, values between -2 and 2, or anything
    function automatic logic signed [VAL_W-1:0] pick_q16();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3, 4, 5: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom();
        endcase
    endfunction

    // Cell index: mostly a small hot set so readouts find accumulated sums
    function automatic logic [CELL_IDX_W-1:0] pick_cell();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 12'($urandom_range(7));
            5:             return 12'hFF8 + 12'($urandom_range(7));
            default:       return 12'($urandom());
        endcase
    endfunction

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** face_flux_divergence_correction_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         roll;
        logic [1:0] func;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a clean cell reads back the prior unchanged
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd0,
                     32'sh0001_0000, 32'sh0001_0000, 32'sh7FFF_FFFF);
        // every face kind, extreme fluxes, edge cells, owner equal to neighbour
        send_request(FUNC_BOUNDARY, 12'd0, 12'hFFF, 32'sh7FFF_FFFF, 1'b1, 12'd0, '0, '0, '0);
        send_request(FUNC_PROCESSOR, 12'hFFF, 12'd0, 32'sh8000_0000, 1'b1, 12'd0, '0, '0, '0);
        send_request(FUNC_PROCESSOR, 12'hFFF, 12'd0, 32'sh8000_0000, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_INTERNAL, 12'd5, 12'hFFF, 32'sh0001_0000, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_INTERNAL, 12'd7, 12'd7, 32'sh1234_5678, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd0,
                     32'sh0001_0000, 32'sh0001_0000, '0);
        // product too large for 32 bits, plus a small and a zero product
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'hFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd5,
                     32'shFFFF_0000, 32'sh0001_0000, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd7,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_1234);
        send_request(FUNC_BOUNDARY, 12'd9, 12'd0, 32'sh8000_0000, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd9,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // rounding ties of both signs go away from zero
        send_request(FUNC_BOUNDARY, 12'd10, 12'd0, 32'sh0000_0001, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd10,
                     32'sh0000_8000, 32'sh0001_0000, '0);
        send_request(FUNC_BOUNDARY, 12'd11, 12'd0, 32'shFFFF_FFFF, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd11,
                     32'sh0000_8000, 32'sh0001_0000, '0);
        // difference clamps at both ends of the 32-bit range
        send_request(FUNC_BOUNDARY, 12'd12, 12'd0, 32'sh0001_0000, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd12,
                     32'sh0001_0000, 32'sh0001_0000, 32'sh8000_0000);
        send_request(FUNC_BOUNDARY, 12'd13, 12'd0, 32'shFFFF_0000, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd13,
                     32'sh0001_0000, 32'sh0001_0000, 32'sh7FFF_FFFF);

        // Drive one cell into positive sum saturation, then one into negative
        gap_pct = 30;
        for (int n = 0; n < SAT_FACES; n++)
            send_request(FUNC_BOUNDARY, 12'd100, 12'($urandom()),
                         32'h7F00_0000 + $urandom_range(32'h00FF_FFFF), 1'($urandom()),
                         12'($urandom()), pick_q16(), pick_q16(), pick_q16());
        send_request(FUNC_INTERNAL, 12'd100, 12'd100, 32'sh7FFF_FFFF, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd100,
                     32'sh0001_0000, 32'sh0001_0000, '0);
        for (int n = 0; n < SAT_FACES; n++)
            send_request(FUNC_PROCESSOR, 12'd200, 12'($urandom()),
                         32'h7F00_0000 + $urandom_range(32'h00FF_FFFF), 1'b0,
                         12'($urandom()), pick_q16(), pick_q16(), pick_q16());
        send_request(FUNC_INTERNAL, 12'd200, 12'd200, 32'sh8000_0000, 1'b0, 12'd0, '0, '0, '0);
        send_request(FUNC_READOUT, 12'd0, 12'd0, '0, 1'b0, 12'd200,
                     pick_q16(), pick_q16(), pick_q16());

        // Random mix of faces and readouts, idling varied in segments
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                roll    = $urandom_range(2);
                gap_pct = (n >= RANDOM_ITEMS - CALM_TAIL) ? 0 :
                          (roll == 0) ? 0 : (roll == 1) ? 25 : 60;
            end
            roll = $urandom_range(99);
            func = (roll < 35) ? FUNC_INTERNAL :
                   (roll < 55) ? FUNC_BOUNDARY :
                   (roll < 75) ? FUNC_PROCESSOR : FUNC_READOUT;
            send_request(func, pick_cell(), pick_cell(), pick_q16(), 1'($urandom()),
                         pick_cell(), pick_q16(), pick_q16(), pick_q16());
        end
        start <= 1'b0;

        // Drain outstanding readouts, then let the pipeline settle
        @(posedge i_clk);
        while (pending_readouts != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending_readouts == 0)
            $display("** face_flux_divergence_correction_core: PASSED **");
        else
            $display("** face_flux_divergence_correction_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/ffdc_pkg.sv
hdl/ffdc_corr_unit.sv
hdl/face_flux_divergence_correction_core.sv
test/ffdc_outflow_checker.sv
test/face_flux_divergence_correction_core_tb.sv
